FILE: src/fcht_pkg.sv
`timescale 1ns / 1ps

package fcht_pkg;

  // Field and arithmetic widths
  localparam int unsigned ChanW    = 16;         // Q4.12 colour channel
  localparam int unsigned FracW    = 12;         // fraction bits of Q4.12
  localparam int unsigned EngW     = ChanW + 1;  // engine far end, near + range
  localparam int unsigned MulW     = 18;         // shared multiplier operand
  localparam int unsigned ProdW    = 2 * MulW;   // multiplier product
  localparam int unsigned LumaW    = 18;         // luma of a 17-bit colour
  localparam int unsigned LumaShft = 16;         // luma coefficients are Q0.16
  localparam int unsigned EndW     = 22;         // shaded end, full width
  localparam int unsigned DiffW    = EndW + 1;   // far end minus new near
  localparam int unsigned CountW   = 32;
  localparam int unsigned OpW      = 2;

  localparam int unsigned Channels = 3;
  localparam int unsigned ChIdxW   = $clog2(Channels);

  // Divider retires two quotient bits per step
  localparam int unsigned DivSteps = ChanW / 2;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration registers
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned GainW    = 13;
  localparam int unsigned CapW     = 15;
  localparam int unsigned DarkW    = 13;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegShadeGain = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHueCap    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDarkLimit = 2'd2;

  localparam logic [GainW-1:0] ShadeGainRst = 13'd2458;  // 0.6
  localparam logic [CapW-1:0]  HueCapRst    = 15'd12288; // 3.0
  localparam logic [DarkW-1:0] DarkLimitRst = 13'd4;     // ~0.001

  // Operation codes
  localparam logic [OpW-1:0] OpSet    = 2'd0;
  localparam logic [OpW-1:0] OpTint   = 2'd1;
  localparam logic [OpW-1:0] OpForget = 2'd2;

  // Channel indexes
  localparam logic [ChIdxW-1:0] ChRed   = 2'd0;
  localparam logic [ChIdxW-1:0] ChGreen = 2'd1;
  localparam logic [ChIdxW-1:0] ChBlue  = 2'd2;

  // Rec.601 luma weights, Q0.16, summing to 1.0
  localparam logic signed [MulW-1:0] LumaCoefR = 18'sd19595;
  localparam logic signed [MulW-1:0] LumaCoefG = 18'sd38470;
  localparam logic signed [MulW-1:0] LumaCoefB = 18'sd7471;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic signed [ChanW-1:0] first_r;
    logic signed [ChanW-1:0] first_g;
    logic signed [ChanW-1:0] first_b;
    logic signed [ChanW-1:0] first_w;
    logic signed [ChanW-1:0] second_r;
    logic signed [ChanW-1:0] second_g;
    logic signed [ChanW-1:0] second_b;
    logic signed [ChanW-1:0] second_w;
  } in_item_t;

  typedef struct packed {
    logic signed [ChanW-1:0] near_r;
    logic signed [ChanW-1:0] near_g;
    logic signed [ChanW-1:0] near_b;
    logic signed [ChanW-1:0] near_w;
    logic signed [ChanW-1:0] span_r;
    logic signed [ChanW-1:0] span_g;
    logic signed [ChanW-1:0] span_b;
    logic signed [ChanW-1:0] span_w;
    logic [CountW-1:0]       tints_so_far;
  } out_item_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_MUL_LUMA,
    CMD_ACC,
    CMD_LUMA,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_HUE_WR,
    CMD_MUL_BRT,
    CMD_BRT,
    CMD_MUL_SHD,
    CMD_SHD_WR,
    CMD_SET_DONE,
    CMD_FORGET,
    CMD_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [ChIdxW-1:0] ch;
    logic              far_sel;  // 0 toward / near end, 1 away / far end
  } dp_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           horizon_valid;
    logic           out_free;
  } dp_status_t;

endpackage

FILE: src/fcht_ctrl.sv
`timescale 1ns / 1ps

module fcht_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fcht_pkg::dp_status_t status_i,
  output fcht_pkg::dp_cmd_t    cmd_o
);
  import fcht_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DECODE   = 13'b0000000000010,
    S_LUMA_MUL = 13'b0000000000100,
    S_LUMA_ACC = 13'b0000000001000,
    S_LUMA_RND = 13'b0000000010000,
    S_DIV_INIT = 13'b0000000100000,
    S_DIV_STEP = 13'b0000001000000,
    S_HUE_WR   = 13'b0000010000000,
    S_BRT_MUL  = 13'b0000100000000,
    S_BRT_RND  = 13'b0001000000000,
    S_SHD_MUL  = 13'b0010000000000,
    S_SHD_WR   = 13'b0100000000000,
    S_FINISH   = 13'b1000000000000
  } state_e;

  state_e             state_q, state_d;
  logic [ChIdxW-1:0]  ch_q, ch_d;
  logic               far_q, far_d;
  logic [DivCntW-1:0] step_q, step_d;
  logic               is_set;

  assign is_set = (status_i.op == OpSet);

  always_comb begin
    state_d       = state_q;
    ch_d          = ch_q;
    far_d         = far_q;
    step_d        = step_q;
    in_stall_o    = 1'b1;
    cmd_o.op      = CMD_NONE;
    cmd_o.ch      = ch_q;
    cmd_o.far_sel = far_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = CMD_CAPTURE;
          ch_d     = ChRed;
          far_d    = 1'b0;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.op)
          OpSet:    state_d = S_LUMA_MUL;
          OpTint:   state_d = status_i.horizon_valid ? S_LUMA_MUL : S_IDLE;
          OpForget: begin
            cmd_o.op = CMD_FORGET;
            state_d  = S_IDLE;
          end
          default:  state_d = S_IDLE;
        endcase
      end
      S_LUMA_MUL: begin
        cmd_o.op = CMD_MUL_LUMA;
        state_d  = S_LUMA_ACC;
      end
      S_LUMA_ACC: begin
        cmd_o.op = CMD_ACC;
        if (ch_q == ChBlue) begin
          ch_d    = ChRed;
          state_d = S_LUMA_RND;
        end else begin
          ch_d    = ch_q + ChIdxW'(1);
          state_d = S_LUMA_MUL;
        end
      end
      S_LUMA_RND: begin
        cmd_o.op = CMD_LUMA;
        state_d  = is_set ? S_DIV_INIT : S_BRT_MUL;
      end
      S_DIV_INIT: begin
        cmd_o.op = CMD_DIV_INIT;
        step_d   = '0;
        state_d  = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.op = CMD_DIV_STEP;
        step_d   = step_q + DivCntW'(1);
        if (step_q == DivCntW'(DivSteps - 1)) state_d = S_HUE_WR;
      end
      S_HUE_WR, S_SHD_WR: begin
        cmd_o.op = (state_q == S_HUE_WR) ? CMD_HUE_WR : CMD_SHD_WR;
        if (ch_q != ChBlue) begin
          ch_d    = ch_q + ChIdxW'(1);
          state_d = (state_q == S_HUE_WR) ? S_DIV_INIT : S_SHD_MUL;
        end else begin
          ch_d = ChRed;
          if (far_q) begin
            state_d = S_FINISH;
          end else begin
            far_d   = 1'b1;
            state_d = S_LUMA_MUL;
          end
        end
      end
      S_BRT_MUL: begin
        cmd_o.op = CMD_MUL_BRT;
        state_d  = S_BRT_RND;
      end
      S_BRT_RND: begin
        cmd_o.op = CMD_BRT;
        state_d  = S_SHD_MUL;
      end
      S_SHD_MUL: begin
        cmd_o.op = CMD_MUL_SHD;
        state_d  = S_SHD_WR;
      end
      S_FINISH: begin
        if (is_set) begin
          cmd_o.op = CMD_SET_DONE;
          state_d  = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = CMD_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= ChRed;
      far_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      far_q   <= far_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: src/fcht_dp.sv
`timescale 1ns / 1ps

module fcht_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcht_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fcht_pkg::CfgDataW-1:0]    cfg_data_i,
  input  fcht_pkg::in_item_t               in_data_i,
  output fcht_pkg::out_item_t              out_data_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  fcht_pkg::dp_cmd_t                cmd_i,
  output fcht_pkg::dp_status_t             status_o
);
  import fcht_pkg::*;

  localparam logic signed [ProdW-1:0] LumaHalf = ProdW'(1) << (LumaShft - 1);
  localparam logic signed [ProdW-1:0] FracHalf = ProdW'(1) << (FracW - 1);

  function automatic logic signed [ChanW-1:0] sat_chan(input logic signed [DiffW-1:0] x);
    logic [DiffW-ChanW:0] hi_bits;
    hi_bits = x[DiffW-1:ChanW-1];
    if (hi_bits == '0 || hi_bits == '1) return x[ChanW-1:0];
    else if (x[DiffW-1]) return {1'b1, {(ChanW-1){1'b0}}};
    else return {1'b0, {(ChanW-1){1'b1}}};
  endfunction

  // configuration
  logic [GainW-1:0] gain_q;
  logic [CapW-1:0]  cap_q;
  logic [DarkW-1:0] dark_q;

  // held horizon and counters
  logic signed [ChanW-1:0] toward_hue_q [Channels];
  logic signed [ChanW-1:0] away_hue_q   [Channels];
  logic                    toward_has_q, away_has_q, horizon_q, out_valid_q;
  logic [CountW-1:0]       tint_count_q;

  // working registers
  in_item_t                in_q;
  out_item_t               out_q, out_d;
  logic signed [ProdW-1:0] p_q, acc_q;
  logic signed [LumaW-1:0] luma_q;
  logic signed [MulW-1:0]  bright_q;
  logic signed [EndW-1:0]  nend_q [Channels];
  logic signed [EndW-1:0]  fend_q [Channels];
  logic [ChanW-1:0]        rem_q, div_q, dlo_q, quot_q;
  logic                    ovf_q, neg_q;

  // combinational
  logic signed [ChanW-1:0] first_c, second_c, hue_c, hue_v;
  logic signed [MulW-1:0]  coef_c, mul_a, mul_b;
  logic signed [EngW-1:0]  first_x, second_x, eng_c;
  logic [EngW-1:0]         eng_abs;
  logic [ChanW-1:0]        mag, rem_init;
  logic signed [ProdW-1:0] acc_rnd, p_rnd;
  logic signed [EndW-1:0]  end_v;
  logic                    is_tint, dark_c, has_c;
  logic [ChanW:0]          dv, r1, r2, m1, m2;
  logic                    ge1, ge2;
  logic signed [ChanW-1:0] n_v [Channels];
  logic signed [ChanW-1:0] s_v [Channels];

  always_comb begin
    unique case (cmd_i.ch)
      ChRed: begin
        first_c  = in_q.first_r;
        second_c = in_q.second_r;
        coef_c   = LumaCoefR;
      end
      ChGreen: begin
        first_c  = in_q.first_g;
        second_c = in_q.second_g;
        coef_c   = LumaCoefG;
      end
      default: begin
        first_c  = in_q.first_b;
        second_c = in_q.second_b;
        coef_c   = LumaCoefB;
      end
    endcase
  end

  // far end of a tint is near + range, kept exact at 17 bits
  assign is_tint  = (in_q.operation == OpTint);
  assign first_x  = EngW'(first_c);
  assign second_x = EngW'(second_c);
  assign eng_c    = cmd_i.far_sel ? (is_tint ? first_x + second_x : second_x) : first_x;
  assign hue_c    = cmd_i.far_sel ? away_hue_q[cmd_i.ch] : toward_hue_q[cmd_i.ch];
  assign has_c    = cmd_i.far_sel ? away_has_q : toward_has_q;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      CMD_MUL_LUMA: begin
        mul_a = MulW'(eng_c);
        mul_b = coef_c;
      end
      CMD_MUL_BRT: begin
        mul_a = luma_q;
        mul_b = $signed(MulW'(gain_q));
      end
      CMD_MUL_SHD: begin
        mul_a = MulW'(hue_c);
        mul_b = bright_q;
      end
      default: ;
    endcase
  end

  assign acc_rnd = acc_q + LumaHalf;
  assign p_rnd   = p_q + FracHalf;
  assign end_v   = has_c ? p_rnd[FracW +: EndW] : EndW'(eng_c);

  // divider set-up: dividend is |c| << 12
  assign eng_abs  = eng_c[EngW-1] ? -eng_c : eng_c;
  assign mag      = eng_abs[ChanW-1:0];
  assign rem_init = ChanW'(mag[ChanW-1:ChanW-FracW]);

  // two restoring steps
  assign dv  = {1'b0, div_q};
  assign r1  = {rem_q, dlo_q[ChanW-1]};
  assign ge1 = (r1 >= dv);
  assign m1  = ge1 ? r1 - dv : r1;
  assign r2  = {m1[ChanW-1:0], dlo_q[ChanW-2]};
  assign ge2 = (r2 >= dv);
  assign m2  = ge2 ? r2 - dv : r2;

  // hue from quotient, capped above, saturated below
  assign dark_c = luma_q[LumaW-1] || (luma_q == '0) ||
                  (luma_q[LumaW-2:0] < (LumaW-1)'(dark_q));

  always_comb begin
    if (dark_c) begin
      hue_v = '0;
    end else if (!neg_q) begin
      hue_v = (ovf_q || quot_q > ChanW'(cap_q)) ? ChanW'(cap_q) : quot_q;
    end else begin
      hue_v = (ovf_q || quot_q[ChanW-1]) ? {1'b1, {(ChanW-1){1'b0}}} : -quot_q;
    end
  end

  always_comb begin
    for (int i = 0; i < Channels; i++) begin
      n_v[i] = sat_chan(DiffW'(nend_q[i]));
      s_v[i] = sat_chan(DiffW'(fend_q[i]) - DiffW'(n_v[i]));
    end
    out_d.near_r       = n_v[ChRed];
    out_d.near_g       = n_v[ChGreen];
    out_d.near_b       = n_v[ChBlue];
    out_d.near_w       = in_q.first_w;
    out_d.span_r       = s_v[ChRed];
    out_d.span_g       = s_v[ChGreen];
    out_d.span_b       = s_v[ChBlue];
    out_d.span_w       = in_q.second_w;
    out_d.tints_so_far = tint_count_q + CountW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= ShadeGainRst;
      cap_q        <= HueCapRst;
      dark_q       <= DarkLimitRst;
      toward_has_q <= 1'b0;
      away_has_q   <= 1'b0;
      horizon_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      tint_count_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        toward_hue_q[i] <= '0;
        away_hue_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegShadeGain: gain_q <= cfg_data_i[GainW-1:0];
          RegHueCap:    cap_q  <= cfg_data_i[CapW-1:0];
          RegDarkLimit: dark_q <= cfg_data_i[DarkW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == CMD_EMIT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        CMD_HUE_WR: begin
          if (cmd_i.far_sel) begin
            away_hue_q[cmd_i.ch] <= hue_v;
            away_has_q           <= !dark_c;
          end else begin
            toward_hue_q[cmd_i.ch] <= hue_v;
            toward_has_q           <= !dark_c;
          end
        end
        CMD_SET_DONE: horizon_q <= 1'b1;
        CMD_FORGET:   horizon_q <= 1'b0;
        CMD_EMIT:     tint_count_q <= tint_count_q + CountW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      CMD_CAPTURE: in_q <= in_data_i;
      CMD_ACC:     acc_q <= (cmd_i.ch == ChRed) ? p_q : acc_q + p_q;
      CMD_LUMA:    luma_q <= acc_rnd[LumaShft +: LumaW];
      CMD_DIV_INIT: begin
        div_q  <= luma_q[ChanW-1:0];
        rem_q  <= rem_init;
        dlo_q  <= {mag[ChanW-FracW-1:0], {FracW{1'b0}}};
        ovf_q  <= (rem_init >= luma_q[ChanW-1:0]);
        neg_q  <= eng_c[EngW-1];
        quot_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q  <= m2[ChanW-1:0];
        dlo_q  <= dlo_q << 2;
        quot_q <= {quot_q[ChanW-3:0], ge1, ge2};
      end
      CMD_BRT: bright_q <= p_rnd[FracW +: MulW];
      CMD_SHD_WR: begin
        if (cmd_i.far_sel) fend_q[cmd_i.ch] <= end_v;
        else nend_q[cmd_i.ch] <= end_v;
      end
      CMD_EMIT: out_q <= out_d;
      default: ;
    endcase
  end

  assign out_data_o             = out_q;
  assign out_valid_o            = out_valid_q;
  assign status_o.op            = in_q.operation;
  assign status_o.horizon_valid = horizon_q;
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

`ifndef SYNTH
  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_DIV_STEP && !ovf_q) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_horizon_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(horizon_q) |-> $past(cmd_i.op == CMD_FORGET))
    else $error("horizon dropped without forget");

  a_emit_needs_horizon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_EMIT) |-> (horizon_q && (!out_valid_q || !out_stall_i)))
    else $error("tint result loaded without horizon or over a pending result");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_EMIT) |=> (out_valid_q && out_q.tints_so_far == tint_count_q))
    else $error("tint count and emitted result disagree");
`endif

endmodule

FILE: src/fog_colour_hue_tint.sv
// Fog colour hue tint.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one request at a
// time: set horizon (toward and away sky colours), tint (near fog colour and
// range) or forget horizon. Output channel (out_valid_o / out_stall_i /
// out_data_o) carries one result per tint while a horizon is held.
// Work per request:
//   set horizon     two 3-tap luma MACs, six 8-step radix-4 divides
//   tint            two lumas, two gains, six shades on one multiplier
//   forget / other  decode only
// A tint result is held in the output register until taken. The input
// side stays free while a result waits; a further tint holds in its final
// state until the output register empties, so a stalled receiver stops the
// block at the next tint request.
// Configuration (cfg_we_i / cfg_index_i / cfg_data_i) writes shade gain, hue
// cap and dark limit; write only while idle.
// Reset (rst_ni, async, active low) loads the register defaults, drops the
// horizon, zeroes hues and the tint count, and empties the output register.
`timescale 1ns / 1ps

module fog_colour_hue_tint (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [fcht_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fcht_pkg::CfgDataW-1:0] cfg_data_i,
  // request in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fcht_pkg::in_item_t            in_data_i,
  // result out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fcht_pkg::out_item_t           out_data_o
);
  import fcht_pkg::*;

  dp_cmd_t    cmd;     // micro-op for this cycle
  dp_status_t status;  // captured operation, horizon flag, output slot

  // Sequencer: walks luma, divide or shade steps per channel and end
  fcht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: one 18x18 multiplier, accumulator, radix-4 divider, horizon
  // store, config registers and output register
  fcht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

FILE: bench/tb_fog_colour_hue_tint.sv
`timescale 1ns / 1ps

module tb_fog_colour_hue_tint;
  import fcht_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [OpW-1:0]     OpUnused = 2'd3;  // no operation, must be ignored
  localparam logic [CfgIdxW-1:0] RegNone  = 2'd3;  // beyond the register list

  localparam int QuietLimit   = 4000;  // cycles with no handshake before giving up
  localparam int SettleCycles = 100;   // covers a set, which has no result
  localparam int HoldAfter    = 40;    // results seen before the long receiver hold
  localparam int HoldCycles   = 600;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_q   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_q  = '0;
  logic [CfgDataW-1:0] cfg_data_q = '0;
  logic                in_valid_q = 1'b0;
  in_item_t            in_data_q  = '0;
  logic                out_stall_q = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_item_t           out_data_o;

  fog_colour_hue_tint u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_we_q),
    .cfg_index_i (cfg_idx_q),
    .cfg_data_i  (cfg_data_q),
    .in_valid_i  (in_valid_q),
    .in_stall_o,
    .in_data_i   (in_data_q),
    .out_valid_o,
    .out_stall_i (out_stall_q),
    .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Our own copy of the block: registers, horizon and tint count
  // ---------------------------------------------------------------------------
  int unsigned gain_cfg = ShadeGainRst;
  int unsigned cap_cfg  = HueCapRst;
  int unsigned dark_cfg = DarkLimitRst;

  logic signed [ChanW-1:0] hue_toward [3] = '{default: '0};
  logic signed [ChanW-1:0] hue_away   [3] = '{default: '0};
  bit                      toward_lit   = 1'b0;  // toward end has a hue
  bit                      away_lit     = 1'b0;
  bit                      horizon_held = 1'b0;
  logic [CountW-1:0]       tint_total   = '0;

  in_item_t  queued_reqs [$];  // requests waiting for the driver
  out_item_t due_tints   [$];  // tint results still to come out

  int mismatch_cnt = 0;

  // floor(x / 2^sh + 1/2)
  function automatic longint round_q(input longint x, input int unsigned sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint luma_q(input longint c [3]);
    return round_q(c[0] * longint'(LumaCoefR) + c[1] * longint'(LumaCoefG)
                   + c[2] * longint'(LumaCoefB), LumaShft);
  endfunction

  function automatic logic signed [ChanW-1:0] sat_chan(input longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[ChanW-1:0];
  endfunction

  // hue = colour / luma, capped above; dark or non-positive luma gives no hue
  function automatic bit derive_hue(input longint c [3],
                                    output logic signed [ChanW-1:0] hue [3]);
    longint lum, q;
    lum = luma_q(c);
    if (lum < longint'(dark_cfg) || lum <= 0) begin
      foreach (hue[i]) hue[i] = '0;
      return 1'b0;
    end
    foreach (hue[i]) begin
      q = (c[i] * 4096) / lum;  // truncates toward zero
      if (q > longint'(cap_cfg)) q = longint'(cap_cfg);
      hue[i] = sat_chan(q);
    end
    return 1'b1;
  endfunction

  // hued end = hue * (engine luma * gain), kept at full width
  function automatic void shade_end(input longint eng [3],
                                    input logic signed [ChanW-1:0] hue [3],
                                    input bit lit, output longint res [3]);
    longint brt;
    brt = round_q(luma_q(eng) * longint'(gain_cfg), FracW);
    foreach (res[i]) res[i] = lit ? round_q(longint'(hue[i]) * brt, FracW) : eng[i];
  endfunction

  // Advance our copy by one accepted request; a tint under a horizon owes a result
  function automatic void apply_request(input in_item_t req);
    longint a [3], b [3], far_e [3], near_end [3], far_end [3];
    logic signed [ChanW-1:0] near_sat [3], span_sat [3];
    out_item_t res;
    a[0] = longint'(req.first_r);
    a[1] = longint'(req.first_g);
    a[2] = longint'(req.first_b);
    b[0] = longint'(req.second_r);
    b[1] = longint'(req.second_g);
    b[2] = longint'(req.second_b);
    case (req.operation)
      OpSet: begin
        toward_lit   = derive_hue(a, hue_toward);
        away_lit     = derive_hue(b, hue_away);
        horizon_held = 1'b1;
      end
      OpForget: horizon_held = 1'b0;  // hues stay
      OpTint: begin
        if (horizon_held) begin
          foreach (far_e[i]) far_e[i] = a[i] + b[i];  // 17 bits, never saturated
          shade_end(a, hue_toward, toward_lit, near_end);
          shade_end(far_e, hue_away, away_lit, far_end);
          tint_total = tint_total + 1;
          for (int i = 0; i < 3; i++) begin
            near_sat[i] = sat_chan(near_end[i]);
            span_sat[i] = sat_chan(far_end[i] - longint'(near_sat[i]));
          end
          res.near_r       = near_sat[0];
          res.near_g       = near_sat[1];
          res.near_b       = near_sat[2];
          res.near_w       = req.first_w;
          res.span_r       = span_sat[0];
          res.span_g       = span_sat[1];
          res.span_b       = span_sat[2];
          res.span_w       = req.second_w;
          res.tints_so_far = tint_total;
          due_tints.push_back(res);
        end
      end
      default: ;  // unused code: nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps between them
  // ---------------------------------------------------------------------------
  int gap_left   = 0;
  int burst_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid_q && !in_stall_o) apply_request(in_data_q);
      if (!in_valid_q || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_q <= 1'b0;
        end else if (queued_reqs.size() != 0) begin
          in_data_q  <= queued_reqs.pop_front();
          in_valid_q <= 1'b1;
          if (burst_left != 0) begin
            burst_left <= burst_left - 1;
          end else begin
            // burst over: a quarter of the time carry straight on
            burst_left <= $urandom_range(0, 15);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result and drives the receiver's stall
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 100)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_mismatch(name, got, want);
  endtask

  int          results_seen = 0;
  logic [31:0] stall_cycle  = '0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  always @(posedge clk_i) begin : result_check
    out_item_t got, want;
    if (!rst_ni) begin
      out_stall_q <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_q) begin
        got = out_data_o;
        results_seen++;
        if (due_tints.size() == 0) begin
          flag_mismatch("result with none expected", got.tints_so_far, '0);
        end else begin
          want = due_tints.pop_front();
          compare_field("near_r", got.near_r, want.near_r);
          compare_field("near_g", got.near_g, want.near_g);
          compare_field("near_b", got.near_b, want.near_b);
          compare_field("near_w", got.near_w, want.near_w);
          compare_field("span_r", got.span_r, want.span_r);
          compare_field("span_g", got.span_g, want.span_g);
          compare_field("span_b", got.span_b, want.span_b);
          compare_field("span_w", got.span_w, want.span_w);
          compare_field("tints_so_far", got.tints_so_far, want.tints_so_far);
        end
      end

      // Stall pattern: long hold once, otherwise a mode chosen by stall_cycle[9:8]
      stall_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_q <= 1'b1;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        // block fills and must push back on the sender
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall_q <= 1'b1;
      end else begin
        case (stall_cycle[9:8])
          2'd0:    out_stall_q <= 1'b0;
          2'd1:    out_stall_q <= ($urandom_range(0, 99) < 30);
          2'd2:    out_stall_q <= stall_cycle[2];
          default: out_stall_q <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Watchdog: no handshake of any kind for too long
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q) || cfg_we_q)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [OpW-1:0] op, input int fr, input int fg,
                           input int fb, input int fw, input int sr, input int sg,
                           input int sb, input int sw);
    in_item_t req;
    req.operation = op;
    req.first_r   = 16'(fr);
    req.first_g   = 16'(fg);
    req.first_b   = 16'(fb);
    req.first_w   = 16'(fw);
    req.second_r  = 16'(sr);
    req.second_g  = 16'(sg);
    req.second_b  = 16'(sb);
    req.second_w  = 16'(sw);
    queued_reqs.push_back(req);
  endtask

  // Mostly plausible colours, with near-black, extremes and raw noise mixed in
  function automatic logic [ChanW-1:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 16'($urandom_range(0, 8192));
    if (pick < 55) return 16'(int'($urandom_range(0, 16384)) - 8192);
    if (pick < 70) return 16'(int'($urandom_range(0, 128)) - 64);
    if (pick < 80) begin
      case ($urandom_range(0, 4))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        3:       return 16'hffff;
        default: return 16'h1000;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Mostly set-then-tint runs; forgets, orphan tints and unused codes as noise
  task automatic queue_random(input int count);
    bit             held;
    int unsigned    pick;
    logic [OpW-1:0] op;
    in_item_t       req;
    held = 1'b0;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (!held)
        op = (pick < 70) ? OpSet : (pick < 85) ? OpTint : (pick < 93) ? OpForget : OpUnused;
      else
        op = (pick < 10) ? OpSet : (pick < 88) ? OpTint : (pick < 95) ? OpForget : OpUnused;
      if (op == OpSet) held = 1'b1;
      if (op == OpForget) held = 1'b0;
      req.operation = op;
      req.first_r   = rand_chan();
      req.first_g   = rand_chan();
      req.first_b   = rand_chan();
      req.first_w   = 16'($urandom);
      req.second_r  = rand_chan();
      req.second_g  = rand_chan();
      req.second_b  = rand_chan();
      req.second_w  = 16'($urandom);
      queued_reqs.push_back(req);
    end
  endtask

  // Sender holds off until every owed tint is out and the block has gone quiet
  task automatic drain_results();
    do @(negedge clk_i);
    while (queued_reqs.size() != 0 || in_valid_q || due_tints.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_q   <= 1'b1;
    cfg_idx_q  <= idx;
    cfg_data_q <= val;
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
    case (idx)
      RegShadeGain: gain_cfg = val[GainW-1:0];
      RegHueCap:    cap_cfg  = val[CapW-1:0];
      RegDarkLimit: dark_cfg = val[DarkW-1:0];
      default: ;  // no such register
    endcase
  endtask

  task automatic run_phase(input int gain, input int cap, input int dark, input int count);
    drain_results();
    write_reg(RegShadeGain, CfgDataW'(gain));
    write_reg(RegHueCap, CfgDataW'(cap));
    write_reg(RegDarkLimit, CfgDataW'(dark));
    queue_random(count);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, register defaults
    queue_req(OpTint,   4096, 2048, 1024, 4096, 512, 512, 512, 0);  // no horizon yet
    queue_req(OpForget, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_req(OpUnused, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    // grey toward; strong red away runs into the hue cap
    queue_req(OpSet,    4096, 4096, 4096, 0, 8192, 0, 0, 0);
    queue_req(OpTint,   4096, 2048, 1024, 'h1234, 1000, 2000, 3000, -1);
    // both ends dark: engine colours pass through
    queue_req(OpSet,    0, 0, 0, 0, 3, 3, 3, 0);
    // far = near + range overflows 16 bits
    queue_req(OpTint,   32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767);
    queue_req(OpTint,   -32768, -32768, -32768, 0, -32768, -32768, -32768, 0);
    // brightest toward, away with negative luma
    queue_req(OpSet,    32767, 32767, 32767, 0, -32768, -32768, -32768, 0);
    queue_req(OpTint,   32767, 32767, 32767, 32767, 32767, 32767, 32767, -32768);
    queue_req(OpTint,   -32768, 0, 32767, 0, 0, -32768, 32767, 0);
    // red capped; away with a negative hue channel
    queue_req(OpSet,    32767, 0, 0, 0, -100, 5000, 100, 0);
    queue_req(OpTint,   8192, 4096, 0, 7, -8192, 4096, 4096, 9);
    // luma exactly at the dark limit; mixed-sign away
    queue_req(OpSet,    4, 4, 4, 0, 32767, -32768, 0, 0);
    queue_req(OpTint,   4096, 4096, 4096, 1, 4096, 4096, 4096, 2);
    queue_req(OpUnused, 1, 2, 3, 4, 5, 6, 7, 8);  // horizon must survive
    queue_req(OpTint,   100, 200, 300, 0, -50, -60, -70, 0);
    queue_req(OpForget, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_req(OpTint,   4096, 4096, 4096, 0, 0, 0, 0, 0);  // dropped, count held
    queue_req(OpSet,    4096, 0, 0, 0, 0, 0, 4096, 0);
    queue_req(OpTint,   2048, 2048, 2048, 0, 2048, 2048, 2048, 0);

    // Random phases across register settings, extremes included
    run_phase(4096, 32767, 0, 190);
    run_phase(0, 0, 4096, 180);
    run_phase($urandom_range(0, 4096), $urandom_range(0, 32767), $urandom_range(0, 400), 180);
    drain_results();
    write_reg(RegNone, CfgDataW'($urandom));
    run_phase('h7fff, 32767, 'h7fff, 120);  // gain and dark limit wrap to 13 bits
    run_phase($urandom_range(1000, 4096), $urandom_range(4096, 20000),
              $urandom_range(0, 50), 190);
    run_phase(ShadeGainRst, HueCapRst, DarkLimitRst, 190);

    drain_results();
    if (mismatch_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
